/* rtl/core/tpbr_pkg.sv */
// Shared types and constants for the two-pole band-pass resonator.
package tpbr_pkg;

    // Arithmetic word of the coefficient engine and of the products
    localparam int WIDE = 64;
    // Stored recursion values: signed Q8.40
    localparam int STATE_BITS = 48;
    localparam int STATE_FRAC = 40;
    // 2 * 3.14159 in Q.40, rounded to nearest
    localparam logic [WIDE-1:0] TWOPI_Q40 = 64'd6908429469410;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam int FREQ_W = 17;
    localparam int QUAL_W = 16;
    localparam int RATE_W = 18;
    localparam int CFG_DATA_W = 18;

    localparam logic [CFG_IDX_W-1:0] REG_FREQ = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATE = 2'd2;

    localparam logic [FREQ_W-1:0] FREQ_RESET = 17'd500;
    localparam logic [QUAL_W-1:0] QUAL_RESET = 16'd256;
    localparam logic [RATE_W-1:0] RATE_RESET = 18'd48000;

    // Replacement for a zero center frequency
    localparam logic [WIDE-1:0] FREQ_DEFAULT = 64'd10;
    // Divisors of the cosine series
    localparam logic [RATE_W-1:0] DIV_FACT4 = 18'd24;
    localparam logic [RATE_W-1:0] DIV_FACT6 = 18'd720;

    // Coefficient engine sequencer
    typedef enum logic [3:0] {
        C_IDLE,
        C_MULF,
        C_DIVW,
        C_CHKQ,
        C_DIVQ,
        C_CHKC,
        C_MULG,
        C_MULG2,
        C_MULG3,
        C_DIV24,
        C_DIV720,
        C_MULK1,
        C_MULK2,
        C_MULRW,
        C_MULKG
    } coef_state_t;

    // Filter datapath sequencer
    typedef enum logic [2:0] {
        F_IDLE,
        F_REC,
        F_GAIN,
        F_GAINW,
        F_OUT
    } filt_state_t;

    // Coefficient set handed to the filter datapath
    typedef struct packed {
        logic            busy;
        logic [WIDE-1:0] k1;
        logic [WIDE-1:0] k2;
        logic [WIDE-1:0] kg;
    } coef_bus_t;

endpackage

/* rtl/core/tpbr_sermul.sv */
// Bit-serial shift-add multiplier of two unsigned operands.
module tpbr_sermul #(
    parameter int A_W = 64,
    parameter int B_W = 48
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic               done,
    output logic [A_W+B_W-1:0] product
);

    localparam int CNT_W = $clog2(B_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(B_W - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [A_W-1:0]   a_reg, a_next;
    logic [A_W-1:0]   hi_reg, hi_next;
    logic [B_W-1:0]   lo_reg, lo_next;
    logic [A_W:0]     sum;

    // Add the multiplicand when the current multiplier bit is set, then shift right
    always_comb
    begin
        sum       = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : {(A_W + 1){1'b0}});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = LAST;
            a_next    = a;
            hi_next   = '0;
            lo_next   = b;
        end
        else if (busy_reg)
        begin
            hi_next  = sum[A_W:1];
            lo_next  = {sum[0], lo_reg[B_W-1:1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Hold operands and partial product
    always_ff @(posedge clk)
    begin
        a_reg  <= a_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

/* rtl/core/tpbr_serdiv.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
module tpbr_serdiv #(
    parameter int N_W = 64,
    parameter int D_W = 18
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] num,
    input  logic [D_W-1:0] den,
    output logic           done,
    output logic [N_W-1:0] quot
);

    localparam int CNT_W = $clog2(N_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(N_W - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [D_W-1:0]   den_reg, den_next;
    logic [D_W-1:0]   rem_reg, rem_next;
    logic [N_W-1:0]   quo_reg, quo_next;
    logic [D_W:0]     shifted;
    logic [D_W+1:0]   diff;
    logic             ge;

    // Shift in the next numerator bit and subtract the divisor when it fits
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[N_W-1]};
        diff      = {1'b0, shifted} - {2'b00, den_reg};
        ge        = !diff[D_W+1];
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = LAST;
            den_next  = den;
            rem_next  = '0;
            quo_next  = num;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[D_W-1:0] : shifted[D_W-1:0];
            quo_next = {quo_reg[N_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Hold divisor, remainder and quotient
    always_ff @(posedge clk)
    begin
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

/* rtl/core/tpbr_coef.sv */
// Configuration registers and sequenced coefficient computation.
module tpbr_coef #(
    parameter int COEF_FRAC_BITS = 30
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [tpbr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tpbr_pkg::CFG_DATA_W-1:0]  cfg_data,
    output tpbr_pkg::coef_bus_t              coef
);

    localparam int W = tpbr_pkg::WIDE;
    localparam logic [W-1:0] ONE = 64'd1 << COEF_FRAC_BITS;
    localparam logic [W-1:0] OMEGA_LIMIT = ONE << 8;
    localparam int OMEGA_SH = tpbr_pkg::STATE_FRAC - COEF_FRAC_BITS;
    localparam logic [W-1:0] TWOPI = tpbr_pkg::TWOPI_Q40 >> OMEGA_SH;

    logic [tpbr_pkg::FREQ_W-1:0] freq_reg, freq_next;
    logic [tpbr_pkg::QUAL_W-1:0] qual_reg, qual_next;
    logic [tpbr_pkg::RATE_W-1:0] rate_reg, rate_next;
    tpbr_pkg::coef_state_t       state_reg, state_next;
    logic                        go_reg, go_next;
    logic [W-1:0] omega_reg, omega_next;
    logic [W-1:0] omr_reg, omr_next;
    logic [W-1:0] g_reg, g_next;
    logic [W-1:0] g2_reg, g2_next;
    logic [W-1:0] tmp_reg, tmp_next;
    logic [W-1:0] cosp_reg, cosp_next;
    logic [W-1:0] k1_reg, k1_next;
    logic [W-1:0] k2_reg, k2_next;
    logic [W-1:0] kg_reg, kg_next;

    logic                        mul_start, mul_done;
    logic [W-1:0]                mul_a, mul_b;
    logic [2*W-1:0]              mul_prod;
    logic [W-1:0]                mul_hi;
    logic                        div_start, div_done;
    logic [W-1:0]                div_num, div_quot;
    logic [tpbr_pkg::RATE_W-1:0] div_den;

    logic [W-1:0] f_eff, r_w, cos_mag;
    logic [tpbr_pkg::RATE_W-1:0] sr_eff;
    logic         cfg_hit;

    tpbr_sermul #(.A_W(W), .B_W(W)) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_prod)
    );

    tpbr_serdiv #(.N_W(W), .D_W(tpbr_pkg::RATE_W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Substitute defaults for zero frequency and zero rate
    assign f_eff   = (freq_reg == '0) ? tpbr_pkg::FREQ_DEFAULT : W'(freq_reg);
    assign sr_eff  = (rate_reg == '0) ? tpbr_pkg::RATE_W'(1) : rate_reg;
    assign r_w     = ONE - omr_reg;
    assign cos_mag = cosp_reg[W-1] ? (64'd0 - cosp_reg) : cosp_reg;
    assign mul_hi  = mul_prod[COEF_FRAC_BITS +: W];
    assign cfg_hit = cfg_write && (cfg_index == tpbr_pkg::REG_FREQ
                     || cfg_index == tpbr_pkg::REG_QUAL || cfg_index == tpbr_pkg::REG_RATE);

    // Steer operands of the shared multiplier and divider
    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        div_num = '0;
        div_den = tpbr_pkg::RATE_W'(1);
        unique case (state_reg)
            tpbr_pkg::C_MULF:   begin mul_a = f_eff;     mul_b = tpbr_pkg::TWOPI_Q40; end
            tpbr_pkg::C_MULG:   begin mul_a = omega_reg; mul_b = omega_reg; end
            tpbr_pkg::C_MULG2:  begin mul_a = g_reg;     mul_b = g_reg; end
            tpbr_pkg::C_MULG3:  begin mul_a = g2_reg;    mul_b = g_reg; end
            tpbr_pkg::C_MULK1:  begin mul_a = cos_mag;   mul_b = r_w; end
            tpbr_pkg::C_MULK2:  begin mul_a = r_w;       mul_b = r_w; end
            tpbr_pkg::C_MULRW:  begin mul_a = r_w;       mul_b = omega_reg; end
            tpbr_pkg::C_MULKG:  begin mul_a = omr_reg;   mul_b = omr_reg + tmp_reg; end
            tpbr_pkg::C_DIVW:   begin div_num = tmp_reg; div_den = sr_eff; end
            tpbr_pkg::C_DIVQ:
            begin
                div_num = omega_reg << 8;
                div_den = tpbr_pkg::RATE_W'(qual_reg);
            end
            tpbr_pkg::C_DIV24:  begin div_num = g2_reg;  div_den = tpbr_pkg::DIV_FACT4; end
            tpbr_pkg::C_DIV720: begin div_num = tmp_reg; div_den = tpbr_pkg::DIV_FACT6; end
            default:            begin end
        endcase
    end

    // Advance the coefficient sequence; a register write restarts it
    always_comb
    begin
        freq_next  = freq_reg;
        qual_next  = qual_reg;
        rate_next  = rate_reg;
        state_next = state_reg;
        go_next    = go_reg;
        omega_next = omega_reg;
        omr_next   = omr_reg;
        g_next     = g_reg;
        g2_next    = g2_reg;
        tmp_next   = tmp_reg;
        cosp_next  = cosp_reg;
        k1_next    = k1_reg;
        k2_next    = k2_reg;
        kg_next    = kg_reg;
        mul_start  = 1'b0;
        div_start  = 1'b0;

        unique case (state_reg)
            tpbr_pkg::C_IDLE:
            begin
            end
            tpbr_pkg::C_CHKQ:
            begin
                if (qual_reg == '0 || omega_reg >= OMEGA_LIMIT)
                begin
                    omr_next   = ONE;
                    state_next = tpbr_pkg::C_CHKC;
                end
                else
                begin
                    state_next = tpbr_pkg::C_DIVQ;
                end
            end
            tpbr_pkg::C_CHKC:
            begin
                if ((omega_reg << 2) <= TWOPI)
                begin
                    state_next = tpbr_pkg::C_MULG;
                end
                else
                begin
                    cosp_next  = '0;
                    state_next = tpbr_pkg::C_MULK1;
                end
            end
            tpbr_pkg::C_DIVW, tpbr_pkg::C_DIVQ, tpbr_pkg::C_DIV24, tpbr_pkg::C_DIV720:
            begin
                if (!go_reg)
                begin
                    div_start = 1'b1;
                    go_next   = 1'b1;
                end
                else if (div_done)
                begin
                    go_next = 1'b0;
                    unique case (state_reg)
                        tpbr_pkg::C_DIVW:
                        begin
                            omega_next = div_quot >> OMEGA_SH;
                            state_next = tpbr_pkg::C_CHKQ;
                        end
                        tpbr_pkg::C_DIVQ:
                        begin
                            omr_next   = (div_quot > ONE) ? ONE : div_quot;
                            state_next = tpbr_pkg::C_CHKC;
                        end
                        tpbr_pkg::C_DIV24:
                        begin
                            g2_next    = div_quot;
                            state_next = tpbr_pkg::C_DIV720;
                        end
                        default:
                        begin
                            cosp_next  = ONE - (g_reg >> 1) + g2_reg - div_quot;
                            state_next = tpbr_pkg::C_MULK1;
                        end
                    endcase
                end
            end
            default:
            begin
                // Multiplier steps; the r*omega term is zero when r is zero
                if (!go_reg && state_reg == tpbr_pkg::C_MULRW && r_w == '0)
                begin
                    tmp_next   = '0;
                    state_next = tpbr_pkg::C_MULKG;
                end
                else if (!go_reg)
                begin
                    mul_start = 1'b1;
                    go_next   = 1'b1;
                end
                else if (mul_done)
                begin
                    go_next = 1'b0;
                    unique case (state_reg)
                        tpbr_pkg::C_MULF:
                        begin
                            tmp_next   = mul_prod[W-1:0];
                            state_next = tpbr_pkg::C_DIVW;
                        end
                        tpbr_pkg::C_MULG:
                        begin
                            g_next     = mul_hi;
                            state_next = tpbr_pkg::C_MULG2;
                        end
                        tpbr_pkg::C_MULG2:
                        begin
                            g2_next    = mul_hi;
                            state_next = tpbr_pkg::C_MULG3;
                        end
                        tpbr_pkg::C_MULG3:
                        begin
                            tmp_next   = mul_hi;
                            state_next = tpbr_pkg::C_DIV24;
                        end
                        tpbr_pkg::C_MULK1:
                        begin
                            k1_next    = cosp_reg[W-1] ? (64'd0 - (mul_hi << 1)) : (mul_hi << 1);
                            state_next = tpbr_pkg::C_MULK2;
                        end
                        tpbr_pkg::C_MULK2:
                        begin
                            k2_next    = 64'd0 - mul_hi;
                            state_next = tpbr_pkg::C_MULRW;
                        end
                        tpbr_pkg::C_MULRW:
                        begin
                            tmp_next   = mul_hi;
                            state_next = tpbr_pkg::C_MULKG;
                        end
                        default:
                        begin
                            kg_next    = mul_hi << 1;
                            state_next = tpbr_pkg::C_IDLE;
                        end
                    endcase
                end
            end
        endcase

        // Take a register write and start over
        if (cfg_hit)
        begin
            unique case (cfg_index)
                tpbr_pkg::REG_FREQ: freq_next = cfg_data[tpbr_pkg::FREQ_W-1:0];
                tpbr_pkg::REG_QUAL: qual_next = cfg_data[tpbr_pkg::QUAL_W-1:0];
                default:            rate_next = cfg_data[tpbr_pkg::RATE_W-1:0];
            endcase
            state_next = tpbr_pkg::C_MULF;
            go_next    = 1'b0;
        end
    end

    // Hold configuration and sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg  <= tpbr_pkg::FREQ_RESET;
            qual_reg  <= tpbr_pkg::QUAL_RESET;
            rate_reg  <= tpbr_pkg::RATE_RESET;
            state_reg <= tpbr_pkg::C_MULF;
            go_reg    <= 1'b0;
        end
        else
        begin
            freq_reg  <= freq_next;
            qual_reg  <= qual_next;
            rate_reg  <= rate_next;
            state_reg <= state_next;
            go_reg    <= go_next;
        end
    end

    // Hold intermediate values and coefficients
    always_ff @(posedge clk)
    begin
        omega_reg <= omega_next;
        omr_reg   <= omr_next;
        g_reg     <= g_next;
        g2_reg    <= g2_next;
        tmp_reg   <= tmp_next;
        cosp_reg  <= cosp_next;
        k1_reg    <= k1_next;
        k2_reg    <= k2_next;
        kg_reg    <= kg_next;
    end

    assign coef.busy = (state_reg != tpbr_pkg::C_IDLE);
    assign coef.k1   = k1_reg;
    assign coef.k2   = k2_reg;
    assign coef.kg   = kg_reg;

endmodule

/* rtl/core/tpbr_filt.sv */
// Recursion state and serial datapath of the resonator.
module tpbr_filt #(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 30
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tpbr_pkg::coef_bus_t    coef,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [SAMPLE_BITS-1:0] sample_in,
    input  logic                   clear_first,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [SAMPLE_BITS-1:0] sample_out
);

    localparam int W  = tpbr_pkg::WIDE;
    localparam int SW = tpbr_pkg::STATE_BITS;
    localparam int SH = tpbr_pkg::STATE_FRAC - (SAMPLE_BITS - 1);
    localparam logic signed [W-1:0] T_MAX = (64'sd1 <<< (SW - 1)) - 64'sd1;
    localparam logic signed [W-1:0] T_MIN = -T_MAX - 64'sd1;
    localparam logic signed [W-1:0] Y_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    localparam logic signed [W-1:0] Y_MIN = -Y_MAX - 64'sd1;

    tpbr_pkg::filt_state_t   state_reg, state_next;
    logic [SW-1:0]           recent_reg, recent_next;
    logic [SW-1:0]           older_reg, older_next;
    logic                    out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0]  x_reg, x_next;
    logic [SAMPLE_BITS-1:0]  y_reg, y_next;
    logic [SAMPLE_BITS-1:0]  out_reg, out_next;
    logic                    neg1_reg, neg1_next;
    logic                    neg2_reg, neg2_next;

    logic            accept, load_out;
    logic            m0_start, m0_done, m1_done;
    logic [W-1:0]    m0_a, m1_a;
    logic [SW-1:0]   m0_b, m1_b;
    logic [W+SW-1:0] m0_prod, m1_prod;
    logic [W-1:0]    k1_mag, k2_mag, kg_mag;
    logic [SW-1:0]   rec_mag, old_mag;
    logic [W-1:0]    p0, p1, s0, s1, xs, t64, ymag, y64;
    logic [SW-1:0]   t_sat;

    tpbr_sermul #(.A_W(W), .B_W(SW)) u_mul0 (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (m0_start),
        .a       (m0_a),
        .b       (m0_b),
        .done    (m0_done),
        .product (m0_prod)
    );

    tpbr_sermul #(.A_W(W), .B_W(SW)) u_mul1 (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept),
        .a       (m1_a),
        .b       (m1_b),
        .done    (m1_done),
        .product (m1_prod)
    );

    // Take magnitudes; products run sign-magnitude and truncate toward zero
    assign k1_mag  = coef.k1[W-1] ? (64'd0 - coef.k1) : coef.k1;
    assign k2_mag  = coef.k2[W-1] ? (64'd0 - coef.k2) : coef.k2;
    assign kg_mag  = coef.kg[W-1] ? (64'd0 - coef.kg) : coef.kg;
    assign rec_mag = recent_reg[SW-1] ? (48'd0 - recent_reg) : recent_reg;
    assign old_mag = older_reg[SW-1] ? (48'd0 - older_reg) : older_reg;

    assign in_stall = (state_reg != tpbr_pkg::F_IDLE) || coef.busy;
    assign accept   = in_valid && !in_stall;
    assign load_out = (state_reg == tpbr_pkg::F_OUT) && (!out_valid_reg || !out_stall);

    // Feed both lanes on a new transaction, lane 0 again for the gain
    assign m0_start = accept || (state_reg == tpbr_pkg::F_GAIN);
    assign m0_a     = (state_reg == tpbr_pkg::F_GAIN) ? kg_mag : k1_mag;
    assign m0_b     = (state_reg == tpbr_pkg::F_GAIN) ? rec_mag
                      : (clear_first ? '0 : rec_mag);
    assign m1_a     = k2_mag;
    assign m1_b     = clear_first ? '0 : old_mag;

    // Form t = x + k1*recent + k2*older and the scaled gain output
    always_comb
    begin
        p0    = m0_prod[COEF_FRAC_BITS +: W];
        p1    = m1_prod[COEF_FRAC_BITS +: W];
        s0    = neg1_reg ? (64'd0 - p0) : p0;
        s1    = neg2_reg ? (64'd0 - p1) : p1;
        xs    = {{(W - SAMPLE_BITS){x_reg[SAMPLE_BITS-1]}}, x_reg} << SH;
        t64   = xs + s0 + s1;
        if ($signed(t64) > T_MAX)
        begin
            t_sat = T_MAX[SW-1:0];
        end
        else if ($signed(t64) < T_MIN)
        begin
            t_sat = T_MIN[SW-1:0];
        end
        else
        begin
            t_sat = t64[SW-1:0];
        end
        ymag = p0 >> SH;
        y64  = neg1_reg ? (64'd0 - ymag) : ymag;
    end

    // Sequence one transaction through recursion, gain and output
    always_comb
    begin
        state_next     = state_reg;
        recent_next    = recent_reg;
        older_next     = older_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        neg1_next      = neg1_reg;
        neg2_next      = neg2_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            tpbr_pkg::F_IDLE:
            begin
                if (accept)
                begin
                    x_next     = sample_in;
                    neg1_next  = coef.k1[W-1] ^ (!clear_first && recent_reg[SW-1]);
                    neg2_next  = coef.k2[W-1] ^ (!clear_first && older_reg[SW-1]);
                    state_next = tpbr_pkg::F_REC;
                    if (clear_first)
                    begin
                        recent_next = '0;
                        older_next  = '0;
                    end
                end
            end
            tpbr_pkg::F_REC:
            begin
                // Both lanes run the same length and finish together
                if (m0_done && m1_done)
                begin
                    older_next  = recent_reg;
                    recent_next = t_sat;
                    state_next  = tpbr_pkg::F_GAIN;
                end
            end
            tpbr_pkg::F_GAIN:
            begin
                neg1_next  = coef.kg[W-1] ^ recent_reg[SW-1];
                state_next = tpbr_pkg::F_GAINW;
            end
            tpbr_pkg::F_GAINW:
            begin
                if (m0_done)
                begin
                    if ($signed(y64) > Y_MAX)
                    begin
                        y_next = Y_MAX[SAMPLE_BITS-1:0];
                    end
                    else if ($signed(y64) < Y_MIN)
                    begin
                        y_next = Y_MIN[SAMPLE_BITS-1:0];
                    end
                    else
                    begin
                        y_next = y64[SAMPLE_BITS-1:0];
                    end
                    state_next = tpbr_pkg::F_OUT;
                end
            end
            tpbr_pkg::F_OUT:
            begin
                if (load_out)
                begin
                    out_next       = y_reg;
                    out_valid_next = 1'b1;
                    state_next     = tpbr_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = tpbr_pkg::F_IDLE;
            end
        endcase
    end

    // Hold control and recursion state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tpbr_pkg::F_IDLE;
            recent_reg    <= '0;
            older_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            recent_reg    <= recent_next;
            older_reg     <= older_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold sample payload
    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        neg1_reg <= neg1_next;
        neg2_reg <= neg2_next;
        out_reg  <= out_next;
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = out_reg;

endmodule

/* rtl/core/two_pole_bandpass_resonator_core.sv */
// Top level of the two-pole band-pass resonator.
// Each transaction takes one signed sample and presents one filtered sample:
// two bit-serial multipliers run k1*recent and k2*older side by side over the
// 48 state bits, then one of them runs gain*t over another 48 bits. One
// transaction is in the datapath at a time, so a new one is accepted only once
// the previous one has moved to the output register; the finished sample waits
// in that output register while the next one is accepted.
// After reset and after every register write the coefficients are recomputed by
// a shared 64-bit serial multiplier and divider in up to 12 steps; in_stall stays
// high until they are ready.
module two_pole_bandpass_resonator_core #(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 30
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [tpbr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tpbr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [SAMPLE_BITS-1:0]          sample_in,
    input  logic                            clear_first,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [SAMPLE_BITS-1:0]          sample_out
);

    tpbr_pkg::coef_bus_t coef;

    tpbr_coef #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_coef (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef)
    );

    tpbr_filt #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_filt (
        .clk         (clk),
        .rst_n       (rst_n),
        .coef        (coef),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample_in   (sample_in),
        .clear_first (clear_first),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sample_out  (sample_out)
    );

`ifndef SYNTH
    // Hold off input while coefficients are in flux
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        coef.busy |-> in_stall)
        else $error("input accepted during coefficient update");

    // One transaction at a time in the datapath
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second transaction accepted while busy");

    // A register write restarts the coefficient sequence
    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_write && (cfg_index == tpbr_pkg::REG_FREQ || cfg_index == tpbr_pkg::REG_QUAL
         || cfg_index == tpbr_pkg::REG_RATE)) |=> coef.busy)
        else $error("register write did not restart coefficients");
`endif

endmodule
